// ===== src/energy_beat_detector_top_defines.svh =====
// Assertion macros for the energy beat detector.
// Used by energy_beat_detector_top; expects clk_i and rst_ni in scope.
`ifndef ENERGY_BEAT_DETECTOR_TOP_DEFINES_SVH
`define ENERGY_BEAT_DETECTOR_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define EBD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define EBD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ebd_pkg.sv =====
// Shared types and constants of the energy beat detector.
// No dependencies; imported by all modules of the block.
`default_nettype none

package ebd_pkg;

  // Field widths.
  localparam int unsigned EnergyW = 16;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned ThrW    = 12;
  localparam int unsigned CfgW    = 16;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_BEAT_THRESHOLD = 2'd0,
    REG_DECAY_FACTOR   = 2'd1,
    REG_COOLDOWN_MS    = 2'd2,
    REG_SILENCE_FLOOR  = 2'd3
  } cfg_reg_e;

  // Reset values of the configuration registers.
  localparam logic [ThrW-1:0]    ThresholdRst = 12'd384;
  localparam logic [EnergyW-1:0] DecayRst     = 16'd58982;
  localparam logic [EnergyW-1:0] CooldownRst  = 16'd200;
  localparam logic [EnergyW-1:0] FloorRst     = 16'd3277;

  // Beat level after a detected beat.
  localparam logic [EnergyW-1:0] LevelFull = 16'hFFFF;

  // Configuration seen by the beat decision logic.
  typedef struct packed {
    logic [ThrW-1:0]    beat_threshold;
    logic [EnergyW-1:0] decay_factor;
    logic [EnergyW-1:0] cooldown_ms;
    logic [EnergyW-1:0] silence_floor;
  } cfg_t;

  // Per-item result of the beat decision logic.
  typedef struct packed {
    logic [EnergyW-1:0] level;
    logic               fired;
  } beat_res_t;

endpackage

`default_nettype wire

// ===== src/energy_beat_detector_top.sv =====
// Energy beat detector: one result per input frame. Each item passes the input
// register, then the result register; throughput one item per cycle while the
// result is not stalled, set by the single pass of logic between them. A stalled
// result holds the input register until it drains. Reset sets control state,
// configuration, sum, average, level and beat time, but not data registers or
// ring storage; a fill flag makes unwritten ring entries read as zero.
`default_nettype none
`include "energy_beat_detector_top_defines.svh"

module energy_beat_detector_top import ebd_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [EnergyW-1:0] bass_energy_i,
  input  wire logic [TimeW-1:0]   time_ms_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic      [EnergyW-1:0] beat_level_o,
  output logic                    beat_fired_o,
  output logic      [EnergyW-1:0] history_average_o,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_data_i
);

  cfg_t               cfg_q;
  logic               in_valid_q;
  logic [EnergyW-1:0] in_energy_q;
  logic [TimeW-1:0]   in_time_q;
  logic               out_valid_q;
  logic [EnergyW-1:0] out_level_q;
  logic               out_fired_q;
  logic [EnergyW-1:0] out_avg_q;
  logic               adv;
  logic [EnergyW-1:0] avg;
  beat_res_t          res;

  // The held item moves on when the result register is free or being drained.
  assign adv        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || adv;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.beat_threshold <= ThresholdRst;
      cfg_q.decay_factor   <= DecayRst;
      cfg_q.cooldown_ms    <= CooldownRst;
      cfg_q.silence_floor  <= FloorRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_BEAT_THRESHOLD: cfg_q.beat_threshold <= cfg_data_i[ThrW-1:0];
        REG_DECAY_FACTOR:   cfg_q.decay_factor   <= cfg_data_i;
        REG_COOLDOWN_MS:    cfg_q.cooldown_ms    <= cfg_data_i;
        REG_SILENCE_FLOOR:  cfg_q.silence_floor  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_energy_q <= bass_energy_i;
      in_time_q   <= time_ms_i;
    end
  end

  ebd_history #(
    .HistoryDepth(HISTORY_DEPTH)
  ) u_history (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .energy_i(in_energy_q),
    .avg_o   (avg)
  );

  ebd_beat u_beat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .energy_i(in_energy_q),
    .time_i  (in_time_q),
    .avg_i   (avg),
    .cfg_i   (cfg_q),
    .res_o   (res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_level_q <= res.level;
      out_fired_q <= res.fired;
      out_avg_q   <= avg;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign beat_level_o      = out_level_q;
  assign beat_fired_o      = out_fired_q;
  assign history_average_o = out_avg_q;

  // Checks on the pipeline control and the result.
  `EBD_ASSERT_NOW(a_fired_full, out_valid_o && beat_fired_o, beat_level_o == LevelFull,
    "beat reported without full level")
  `EBD_ASSERT_NOW(a_stall_cause, !in_ready_o, out_valid_o && !out_ready_i,
    "input stalled without a stalled result")
  `EBD_ASSERT_NEXT(a_adv_result, adv, out_valid_o, "processed item produced no result")

endmodule

`default_nettype wire

// ===== src/ebd_history.sv =====
// Energy history ring with running sum and registered average.
// Depends on ebd_pkg.
`default_nettype none

module ebd_history import ebd_pkg::*; #(
  parameter int unsigned HistoryDepth = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               adv_i,
  input  wire logic [EnergyW-1:0] energy_i,
  output logic      [EnergyW-1:0] avg_o
);

  localparam int unsigned IdxW  = $clog2(HistoryDepth);
  localparam int unsigned SumW  = EnergyW + IdxW;
  localparam bit          IsPow2 = (HistoryDepth & (HistoryDepth - 1)) == 0;

  logic [EnergyW-1:0] mem [HistoryDepth];
  logic [EnergyW-1:0] rd_q;
  logic [IdxW-1:0]    idx_q, idx_d, rd_addr;
  logic               wrapped_q;
  logic [SumW-1:0]    sum_q, sum_d;
  logic [EnergyW-1:0] avg_q, avg_d;
  logic [EnergyW-1:0] old_energy;
  logic               idx_last;

  // Entries not yet written since reset read as zero until the ring first wraps.
  assign old_energy = wrapped_q ? rd_q : '0;
  assign sum_d      = sum_q - SumW'(old_energy) + SumW'(energy_i);
  assign idx_last   = idx_q == IdxW'(HistoryDepth - 1);
  assign idx_d      = idx_last ? '0 : idx_q + 1'b1;

  // Prefetch the entry that the next transfer will replace.
  assign rd_addr = adv_i ? idx_d : idx_q;

  // Average of the updated sum, ready for the next item.
  if (IsPow2) begin : g_shift
    assign avg_d = sum_d[SumW-1:IdxW];
  end else begin : g_recip
    localparam int unsigned      Shift = SumW + IdxW;
    localparam int unsigned      MagW  = SumW + 1;
    localparam longint unsigned  Magic =
      ((64'd1 << Shift) + HistoryDepth - 1) / HistoryDepth;
    logic [SumW+MagW-1:0] prod;
    assign prod  = sum_d * MagW'(Magic);
    assign avg_d = EnergyW'(prod >> Shift);
  end

  // Ring storage: a write when an item advances and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      mem[idx_q] <= energy_i;
    end
    rd_q <= mem[rd_addr];
  end

  // Ring pointer, fill flag, running sum and average.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      wrapped_q <= 1'b0;
      sum_q     <= '0;
      avg_q     <= '0;
    end else if (adv_i) begin
      idx_q <= idx_d;
      sum_q <= sum_d;
      avg_q <= avg_d;
      if (idx_last) begin
        wrapped_q <= 1'b1;
      end
    end
  end

  assign avg_o = avg_q;

endmodule

`default_nettype wire

// ===== src/ebd_beat.sv =====
// Beat decision: threshold, silence floor and cooldown tests, level decay.
// Depends on ebd_pkg.
`default_nettype none

module ebd_beat import ebd_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               adv_i,
  input  wire logic [EnergyW-1:0] energy_i,
  input  wire logic [TimeW-1:0]   time_i,
  input  wire logic [EnergyW-1:0] avg_i,
  input  wire cfg_t               cfg_i,
  output beat_res_t               res_o
);

  localparam int unsigned LoudW = EnergyW + ThrW;

  logic [EnergyW-1:0]   level_q, level_d;
  logic [TimeW-1:0]     last_q;
  logic [2*EnergyW-1:0] decay_prod;
  logic [LoudW-1:0]     avg_scaled, energy_scaled;
  logic [TimeW-1:0]     elapsed;
  logic                 loud, above_floor, cooled, fired;

  // Decay truncates toward zero.
  assign decay_prod = level_q * cfg_i.decay_factor;

  // Energy as Q16.8 against average times the Q4.8 threshold, exact.
  assign avg_scaled    = avg_i * cfg_i.beat_threshold;
  assign energy_scaled = LoudW'({energy_i, 8'd0});
  assign loud          = energy_scaled > avg_scaled;
  assign above_floor   = avg_i > cfg_i.silence_floor;

  // Time since the last beat wraps modulo 2^32.
  assign elapsed = time_i - last_q;
  assign cooled  = elapsed > TimeW'(cfg_i.cooldown_ms);

  assign fired   = loud && above_floor && cooled;
  assign level_d = fired ? LevelFull : decay_prod[2*EnergyW-1:EnergyW];

  // Level advances with each processed item; the beat time updates when a beat fires.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
      last_q  <= '0;
    end else if (adv_i) begin
      level_q <= level_d;
      if (fired) begin
        last_q <= time_i;
      end
    end
  end

  assign res_o.level = level_d;
  assign res_o.fired = fired;

endmodule

`default_nettype wire
